[src/lpp_pkg.sv]
// Shared types and constants for the lidar point to pixel projection block.
// No dependencies.
package lpp_pkg;

	localparam int REG_IDX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 64;
	localparam int TRANSLATION_SHIFT = 8;

	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW0_COLS01 = 3'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW0_COLS23 = 3'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW1_COLS01 = 3'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW1_COLS23 = 3'd3;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW2_COLS01 = 3'd4;
	localparam logic [REG_IDX_WIDTH-1:0] REG_ROW2_COLS23 = 3'd5;
	localparam logic [REG_IDX_WIDTH-1:0] REG_IMAGE_WIDTH = 3'd6;
	localparam logic [REG_IDX_WIDTH-1:0] REG_IMAGE_HEIGHT = 3'd7;

	localparam int IMAGE_WIDTH_RESET = 1242;
	localparam int IMAGE_HEIGHT_RESET = 375;

	typedef struct packed {
		logic valid;
		logic w_pos;
		logic u_pos;
		logic v_pos;
	} lpp_ctl_t;

endpackage

[src/lpp_if.sv]
// Valid/ready channel interfaces for points in and pixels out.
// No dependencies.
interface lpp_pt_if #(parameter int COORD_WIDTH = 16);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_px_if #(parameter int PIXEL_WIDTH = 12);
	logic valid;
	logic ready;
	logic [PIXEL_WIDTH-1:0] pixel_col;
	logic [PIXEL_WIDTH-1:0] pixel_row;
	logic in_image;
	modport source(output valid, pixel_col, pixel_row, in_image, input ready);
	modport sink(input valid, pixel_col, pixel_row, in_image, output ready);
endinterface

[src/lpp_row_dot.sv]
// One row of the camera matrix: three products, then their sum with the translation.
// Two pipeline stages; depends on lpp_pkg for the translation shift.
module lpp_row_dot #(
	parameter int COORD_WIDTH = 16,
	parameter int COEF_WIDTH = 32,
	parameter int ACC_W = 50
) (
	input  logic clk,
	input  logic en,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  logic signed [COEF_WIDTH-1:0] c0,
	input  logic signed [COEF_WIDTH-1:0] c1,
	input  logic signed [COEF_WIDTH-1:0] c2,
	input  logic signed [COEF_WIDTH-1:0] c3,
	output logic signed [ACC_W-1:0] sum
);
	localparam int PW = COORD_WIDTH + COEF_WIDTH;

	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [COEF_WIDTH-1:0] c3_s1;
	logic signed [ACC_W-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(c0) * PW'(x);
			p1_s1 <= PW'(c1) * PW'(y);
			p2_s1 <= PW'(c2) * PW'(z);
			c3_s1 <= c3;
			sum_s2 <= ACC_W'(p0_s1) + ACC_W'(p1_s1) + ACC_W'(p2_s1)
				+ (ACC_W'(c3_s1) <<< lpp_pkg::TRANSLATION_SHIFT);
		end
	end

	assign sum = sum_s2;
endmodule

[src/lpp_div_cell.sv]
// One cell of the divider chain: decides quotient bit K for both column and row.
// Depends on lpp_pkg for the control struct.
module lpp_div_cell #(
	parameter int ACC_W = 50,
	parameter int PIXEL_WIDTH = 12,
	parameter int K = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  lpp_pkg::lpp_ctl_t ctl_i,
	input  logic [ACC_W-1:0] ru_i,
	input  logic [ACC_W-1:0] rv_i,
	input  logic [ACC_W-1:0] d_i,
	input  logic [PIXEL_WIDTH:0] qu_i,
	input  logic [PIXEL_WIDTH:0] qv_i,
	output lpp_pkg::lpp_ctl_t ctl_o,
	output logic [ACC_W-1:0] ru_o,
	output logic [ACC_W-1:0] rv_o,
	output logic [ACC_W-1:0] d_o,
	output logic [PIXEL_WIDTH:0] qu_o,
	output logic [PIXEL_WIDTH:0] qv_o
);
	localparam int DW = ACC_W + PIXEL_WIDTH + 1;

	logic [DW-1:0] dsh, du, dv;
	logic bu, bv;
	lpp_pkg::lpp_ctl_t ctl_q;
	logic [ACC_W-1:0] ru_q, rv_q, d_q;
	logic [PIXEL_WIDTH:0] qu_q, qv_q;

	always_comb begin
		dsh = DW'(d_i) << K;
		du = DW'(ru_i) - dsh;
		dv = DW'(rv_i) - dsh;
		bu = DW'(ru_i) >= dsh;
		bv = DW'(rv_i) >= dsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ru_q <= bu ? du[ACC_W-1:0] : ru_i;
			rv_q <= bv ? dv[ACC_W-1:0] : rv_i;
			d_q <= d_i;
			qu_q <= {qu_i[PIXEL_WIDTH-1:0], bu};
			qv_q <= {qv_i[PIXEL_WIDTH-1:0], bv};
		end
	end

	assign ctl_o = ctl_q;
	assign ru_o = ru_q;
	assign rv_o = rv_q;
	assign d_o = d_q;
	assign qu_o = qu_q;
	assign qv_o = qv_q;
endmodule

[src/lidar_point_to_pixel_projection.sv]
// Top level: configuration registers, three row dot products and the divider chain.
// Depends on lpp_pkg, lpp_if, lpp_row_dot and lpp_div_cell.
//
//   channel  | dir | handshake            | payload
//   points   | in  | valid/ready          | point_x, point_y, point_z
//   pixels   | out | valid/ready          | pixel_col, pixel_row, in_image
//   cfg      | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// One transaction per cycle is accepted while the pixels output is not stalled; the
// pipeline is two multiply/sum stages, PIXEL_WIDTH + 1 divider cells and one output stage.
// The whole pipeline advances when the output register is empty or taken,
// so a stall on pixels holds every stage. Reset clears the valid bits and
// loads the default coefficients and image bounds.
module lidar_point_to_pixel_projection #(
	parameter int COORD_WIDTH = 16,
	parameter int COEF_WIDTH = 32,
	parameter int PIXEL_WIDTH = 12
) (
	input  logic clk,
	input  logic arst_n,
	lpp_pt_if.sink points,
	lpp_px_if.source pixels,
	input  logic cfg_we,
	input  logic [lpp_pkg::REG_IDX_WIDTH-1:0] cfg_index,
	input  logic [lpp_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
	localparam int ACC_W = COEF_WIDTH + COORD_WIDTH + 2;
	localparam int NCELL = PIXEL_WIDTH + 1;

	logic signed [COEF_WIDTH-1:0] coef_q [3][4];
	logic [PIXEL_WIDTH-1:0] width_q, height_q;
	logic adv;
	logic valid_s1, valid_s2;
	logic signed [ACC_W-1:0] sum_u, sum_v, sum_w;

	lpp_pkg::lpp_ctl_t ctl_c [NCELL+1];
	logic [ACC_W-1:0] ru_c [NCELL+1];
	logic [ACC_W-1:0] rv_c [NCELL+1];
	logic [ACC_W-1:0] d_c [NCELL+1];
	logic [PIXEL_WIDTH:0] qu_c [NCELL+1];
	logic [PIXEL_WIDTH:0] qv_c [NCELL+1];

	logic out_valid_q;
	logic [PIXEL_WIDTH-1:0] col_q, row_q;
	logic in_image_q;
	logic hit_f;
	logic [PIXEL_WIDTH:0] qu_f, qv_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 4; c++) begin
					coef_q[r][c] <= '0;
				end
			end
			width_q <= PIXEL_WIDTH'(lpp_pkg::IMAGE_WIDTH_RESET);
			height_q <= PIXEL_WIDTH'(lpp_pkg::IMAGE_HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpp_pkg::REG_ROW0_COLS01: begin
					coef_q[0][0] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[0][1] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_ROW0_COLS23: begin
					coef_q[0][2] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[0][3] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_ROW1_COLS01: begin
					coef_q[1][0] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[1][1] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_ROW1_COLS23: begin
					coef_q[1][2] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[1][3] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_ROW2_COLS01: begin
					coef_q[2][0] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[2][1] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_ROW2_COLS23: begin
					coef_q[2][2] <= cfg_data[COEF_WIDTH-1:0];
					coef_q[2][3] <= cfg_data[32+COEF_WIDTH-1:32];
				end
				lpp_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data[PIXEL_WIDTH-1:0];
				lpp_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[PIXEL_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_valid_q || pixels.ready;
	assign points.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= points.valid;
			valid_s2 <= valid_s1;
		end
	end

	lpp_row_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W)) u_row_u (
		.clk(clk), .en(adv), .x(points.point_x), .y(points.point_y), .z(points.point_z),
		.c0(coef_q[0][0]), .c1(coef_q[0][1]), .c2(coef_q[0][2]), .c3(coef_q[0][3]),
		.sum(sum_u)
	);
	lpp_row_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W)) u_row_v (
		.clk(clk), .en(adv), .x(points.point_x), .y(points.point_y), .z(points.point_z),
		.c0(coef_q[1][0]), .c1(coef_q[1][1]), .c2(coef_q[1][2]), .c3(coef_q[1][3]),
		.sum(sum_v)
	);
	lpp_row_dot #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_W(ACC_W)) u_row_w (
		.clk(clk), .en(adv), .x(points.point_x), .y(points.point_y), .z(points.point_z),
		.c0(coef_q[2][0]), .c1(coef_q[2][1]), .c2(coef_q[2][2]), .c3(coef_q[2][3]),
		.sum(sum_w)
	);

	always_comb begin
		ctl_c[0].valid = valid_s2;
		ctl_c[0].w_pos = sum_w > 0;
		ctl_c[0].u_pos = sum_u > 0;
		ctl_c[0].v_pos = sum_v > 0;
		ru_c[0] = (sum_u > 0) ? sum_u : '0;
		rv_c[0] = (sum_v > 0) ? sum_v : '0;
		d_c[0] = sum_w;
		qu_c[0] = '0;
		qv_c[0] = '0;
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lpp_div_cell #(.ACC_W(ACC_W), .PIXEL_WIDTH(PIXEL_WIDTH), .K(PIXEL_WIDTH - i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.ctl_i(ctl_c[i]), .ru_i(ru_c[i]), .rv_i(rv_c[i]), .d_i(d_c[i]),
			.qu_i(qu_c[i]), .qv_i(qv_c[i]),
			.ctl_o(ctl_c[i+1]), .ru_o(ru_c[i+1]), .rv_o(rv_c[i+1]), .d_o(d_c[i+1]),
			.qu_o(qu_c[i+1]), .qv_o(qv_c[i+1])
		);
	end

	// The quotient's top bit marks a value too large for the pixel range.
	always_comb begin
		qu_f = qu_c[NCELL];
		qv_f = qv_c[NCELL];
		hit_f = ctl_c[NCELL].w_pos && ctl_c[NCELL].u_pos && ctl_c[NCELL].v_pos
			&& (qu_f != '0) && (qu_f < {1'b0, width_q})
			&& (qv_f != '0) && (qv_f < {1'b0, height_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_c[NCELL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_q <= hit_f ? qu_f[PIXEL_WIDTH-1:0] : '0;
			row_q <= hit_f ? qv_f[PIXEL_WIDTH-1:0] : '0;
			in_image_q <= hit_f;
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.pixel_col = col_q;
	assign pixels.pixel_row = row_q;
	assign pixels.in_image = in_image_q;
endmodule
